// ----- rtl/shell_word_tokenizer_assert.svh -----
// Assertion macros for the shell word tokenizer checker.
`ifndef SHELL_WORD_TOKENIZER_ASSERT_SVH
`define SHELL_WORD_TOKENIZER_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define SWT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("shell_word_tokenizer assertion failed");

// Implication: a condition now forces a consequence in the next cycle.
`define SWT_ASSERT_NEXT(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("shell_word_tokenizer assertion failed");

`endif

// ----- rtl/swt_pkg.sv -----
package swt_pkg;

   localparam int MAX_WORDS = 255;
   localparam logic [7:0] COUNT_LIMIT = 8'((MAX_WORDS < 255) ? MAX_WORDS : 255);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [7:0] CH_END   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_DOLL  = 8'h24;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_BTICK = 8'h60;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_DONE = 2'd2,
      KIND_ERR  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      M_BETWEEN = 3'd0,
      M_WORD    = 3'd1,
      M_SQ      = 3'd2,
      M_DQ      = 3'd3,
      M_DQ_BS   = 3'd4,
      M_BS      = 3'd5
   } mode_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_val;
      logic [7:0] count;
      logic       last;
   } entry_type;

   // Up to two results produced by one accepted byte.
   typedef struct packed {
      logic [1:0] num;
      entry_type  e0;
      entry_type  e1;
   } push_type;

   function automatic logic is_sep(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
   endfunction

   function automatic logic dq_escapable(input logic [7:0] c);
      return (c == CH_DOLL) || (c == CH_BTICK) || (c == CH_BSL) || (c == CH_DQ);
   endfunction

endpackage

// ----- rtl/swt_lexer.sv -----
module swt_lexer (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [7:0]        char_in,
   output swt_pkg::push_type push
);
   import swt_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [7:0] words_ff, words_in;
   logic [7:0] words_inc;

   assign words_inc = (words_ff < COUNT_LIMIT) ? words_ff + 8'd1 : words_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_BETWEEN;
         words_ff <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         words_ff <= words_in;
      end
   end

   always_comb begin
      push           = '0;
      push.e0.kind   = KIND_BYTE;
      push.e1.kind   = KIND_BYTE;
      push.e0.count  = words_ff;
      push.e1.count  = words_ff;
      mode_in        = mode_ff;
      words_in       = words_ff;

      unique case (mode_ff)
         M_WORD: begin
            if (char_in == CH_END) begin
               // word end then done, both carry the bumped count
               push.num      = 2'd2;
               push.e0.kind  = KIND_END;
               push.e0.count = words_inc;
               push.e1.kind  = KIND_DONE;
               push.e1.count = words_inc;
               mode_in       = M_BETWEEN;
               words_in      = '0;
            end else if (is_sep(char_in)) begin
               push.num      = 2'd1;
               push.e0.kind  = KIND_END;
               push.e0.count = words_inc;
               words_in      = words_inc;
               mode_in       = M_BETWEEN;
            end else if (char_in == CH_SQ) begin
               mode_in = M_SQ;
            end else if (char_in == CH_DQ) begin
               mode_in = M_DQ;
            end else if (char_in == CH_BSL) begin
               mode_in = M_BS;
            end else begin
               push.num         = 2'd1;
               push.e0.byte_val = char_in;
               mode_in          = M_WORD;
            end
         end
         M_SQ: begin
            if (char_in == CH_END) begin
               push.num     = 2'd1;
               push.e0.kind = KIND_ERR;
               mode_in      = M_BETWEEN;
               words_in     = '0;
            end else if (char_in == CH_SQ) begin
               mode_in = M_WORD;
            end else begin
               push.num         = 2'd1;
               push.e0.byte_val = char_in;
            end
         end
         M_DQ: begin
            if (char_in == CH_END) begin
               push.num     = 2'd1;
               push.e0.kind = KIND_ERR;
               mode_in      = M_BETWEEN;
               words_in     = '0;
            end else if (char_in == CH_DQ) begin
               mode_in = M_WORD;
            end else if (char_in == CH_BSL) begin
               mode_in = M_DQ_BS;
            end else begin
               push.num         = 2'd1;
               push.e0.byte_val = char_in;
            end
         end
         M_DQ_BS: begin
            if (char_in == CH_END) begin
               push.num     = 2'd1;
               push.e0.kind = KIND_ERR;
               mode_in      = M_BETWEEN;
               words_in     = '0;
            end else if (dq_escapable(char_in)) begin
               push.num         = 2'd1;
               push.e0.byte_val = char_in;
               mode_in          = M_DQ;
            end else begin
               // backslash kept before a non-special byte
               push.num         = 2'd2;
               push.e0.byte_val = CH_BSL;
               push.e1.byte_val = char_in;
               mode_in          = M_DQ;
            end
         end
         M_BS: begin
            if (char_in == CH_END) begin
               push.num     = 2'd1;
               push.e0.kind = KIND_ERR;
               mode_in      = M_BETWEEN;
               words_in     = '0;
            end else begin
               push.num         = 2'd1;
               push.e0.byte_val = char_in;
               mode_in          = M_WORD;
            end
         end
         default: begin
            // between words; unused codes land here too
            mode_in = M_BETWEEN;
            if (char_in == CH_END) begin
               push.num     = 2'd1;
               push.e0.kind = (words_ff != 8'd0) ? KIND_DONE : KIND_ERR;
               words_in     = '0;
            end else if (is_sep(char_in)) begin
               mode_in = M_BETWEEN;
            end else if (char_in == CH_SQ) begin
               mode_in = M_SQ;
            end else if (char_in == CH_DQ) begin
               mode_in = M_DQ;
            end else if (char_in == CH_BSL) begin
               mode_in = M_BS;
            end else begin
               push.num         = 2'd1;
               push.e0.byte_val = char_in;
               mode_in          = M_WORD;
            end
         end
      endcase

      push.e0.last = (push.num == 2'd1);
      push.e1.last = 1'b1;
   end

endmodule

// ----- rtl/swt_out_queue.sv -----
module swt_out_queue (
   input  logic               clock,
   input  logic               reset,
   input  swt_pkg::push_type  push,
   output logic               space_ok,
   output logic               out_valid,
   input  logic               out_ready,
   output swt_pkg::entry_type out_entry
);
   import swt_pkg::*;

   entry_type          slot_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic [QPTR_W-1:0]  wr_ptr_nx;
   logic               pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (cnt_ff != '0);
   assign out_entry = slot_ff[rd_ptr_ff];
   assign space_ok  = (cnt_ff <= QCNT_W'(QDEPTH - 2));
   assign wr_ptr_nx = wr_ptr_ff + QPTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.num);
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push.num) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.e0;
      end
      if (push.num == 2'd2) begin
         slot_ff[wr_ptr_nx] <= push.e1;
      end
   end

endmodule

// ----- rtl/shell_word_tokenizer.sv -----
// Channel | Ports                                          | Direction
// req     | req_valid, req_ready, req_char_in[7:0]         | in  (one byte per transaction)
// rsp     | rsp_valid, rsp_ready, rsp_kind[1:0],           | out (one result per transaction)
//         | rsp_byte_out[7:0], rsp_word_count[7:0], rsp_last|
//
// One byte is taken per cycle while req_ready is high; its results are written to the
// result queue at that edge and show on rsp the next cycle if the queue was empty.
// Bytes that give two results need two rsp transactions. The rate is set by the single
// read port of the four-entry queue: req_ready is high while two or more slots are free.
// Synchronous active-high reset clears the lexer mode, word counter and queue pointers.
// A stalled rsp side fills the queue and then drops req_ready until space returns.
module shell_word_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_byte_out,
   output logic [7:0] rsp_word_count,
   output logic       rsp_last
);
   import swt_pkg::*;

   logic      req_fire;
   push_type  lex_push;
   push_type  q_push;
   entry_type q_head;

   // transaction accepted on the input side
   assign req_fire = req_valid && req_ready;

   swt_lexer u_lexer (
      .clock   (clock),
      .reset   (reset),
      .fire    (req_fire),
      .char_in (req_char_in),
      .push    (lex_push)
   );

   // only an accepted byte writes into the queue
   always_comb begin
      q_push = lex_push;
      if (!req_fire) begin
         q_push.num = 2'd0;
      end
   end

   swt_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .space_ok  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_entry (q_head)
   );

   assign rsp_kind       = q_head.kind;
   assign rsp_byte_out   = q_head.byte_val;
   assign rsp_word_count = q_head.count;
   assign rsp_last       = q_head.last;

endmodule

// ----- rtl/swt_checker.sv -----
`include "shell_word_tokenizer_assert.svh"

module swt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_char_in,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_byte_out,
   input logic [7:0] rsp_word_count,
   input logic       rsp_last
);
   import swt_pkg::*;

   logic req_seen;
   logic rsp_stall;
   assign req_seen  = req_valid && req_ready && (req_char_in == CH_END);
   assign rsp_stall = rsp_valid && !rsp_ready;

   // only word bytes carry data
   `SWT_ASSERT(a_byte_zero, clock, reset,
      !rsp_valid || (rsp_kind == KIND_BYTE) || (rsp_byte_out == 8'd0))

   // done and error close the byte's results
   `SWT_ASSERT(a_final_last, clock, reset,
      !rsp_valid || !((rsp_kind == KIND_DONE) || (rsp_kind == KIND_ERR)) || rsp_last)

   // done always reports at least one word
   `SWT_ASSERT(a_done_count, clock, reset,
      !(rsp_valid && (rsp_kind == KIND_DONE)) || (rsp_word_count != 8'd0))

   // an end byte always produces something the next cycle
   `SWT_ASSERT_NEXT(a_end_answer, clock, reset, req_seen, rsp_valid)

   // a stalled result holds its transaction
   `SWT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
      rsp_valid && $stable(rsp_kind) && $stable(rsp_byte_out) && $stable(rsp_word_count) && $stable(rsp_last))

endmodule

bind shell_word_tokenizer swt_checker u_swt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_char_in    (req_char_in),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_kind       (rsp_kind),
   .rsp_byte_out   (rsp_byte_out),
   .rsp_word_count (rsp_word_count),
   .rsp_last       (rsp_last)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the shell word tokenizer.
// Bytes go in one transaction at a time on req; every result on rsp is held against a
// queue of tokens from typed rows or a behavioural lexer kept alongside the stimulus.
module testbench;
   import swt_pkg::*;

   localparam int QUIET_LIMIT  = 1000;  // cycles without any transaction before giving up
   localparam int PHASE_ITEMS  = 185;
   localparam int SETTLE_TICKS = 16;

   // One expected result, in the order the rsp ports carry them.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic [7:0] count;
      logic       last;
   } token_t;

   // One row of the directed table. Where typed is set, the row carries its own answer
   // (n_typed tokens in t0/t1) instead of taking the lexer's.
   typedef struct packed {
      logic [7:0] ch;
      logic       typed;
      logic [1:0] n_typed;
      token_t     t0;
      token_t     t1;
   } stim_row_t;

   localparam token_t NO_TOKEN = '0;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_char_in;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_byte_out;
   logic [7:0] rsp_word_count;
   logic       rsp_last;

   shell_word_tokenizer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_in    (req_char_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_word_count (rsp_word_count),
      .rsp_last       (rsp_last)
   );

   // ---------------------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Behavioural lexer: its own mode and word tally, plus a scratch list of the tokens
   // that the latest byte gives rise to.
   // ---------------------------------------------------------------------------------
   mode_type   lex_st      = M_BETWEEN;
   logic [7:0] word_tally  = 8'd0;
   token_t     pend [2];
   int         pend_n;
   token_t     token_q [$];  // tokens still owed by the block, oldest first

   int idle_pct  = 0;  // chance in a hundred that the sender holds back
   int stall_pct = 0;  // chance in a hundred that the receiver stalls
   int item_cnt  = 0;
   int fail_cnt  = 0;

   logic [7:0] line_q [$];
   stim_row_t  dir_tab [26];

   function automatic token_t tok(input kind_type kind, input logic [7:0] data,
                                  input logic [7:0] count, input logic last);
      token_t t;
      t.kind  = kind;
      t.data  = data;
      t.count = count;
      t.last  = last;
      return t;
   endfunction

   function automatic logic is_gap(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_NL;
   endfunction

   task automatic add_token(input kind_type kind, input logic [7:0] data);
      pend[pend_n] = tok(kind, data, word_tally, 1'b0);
      pend_n++;
   endtask

   // End byte seen: report, then forget the line.
   task automatic close_line(input logic ok);
      add_token(ok ? KIND_DONE : KIND_ERR, 8'h00);
      word_tally = 8'd0;
      lex_st     = M_BETWEEN;
   endtask

   task automatic tokenise(input logic [7:0] c);
      logic opens;
      opens  = 1'b0;
      pend_n = 0;
      case (lex_st)
         M_SQ: begin
            if (c == CH_END)     close_line(1'b0);  // quote left open
            else if (c == CH_SQ) lex_st = M_WORD;
            else                 add_token(KIND_BYTE, c);
         end
         M_DQ: begin
            if (c == CH_END)      close_line(1'b0);
            else if (c == CH_DQ)  lex_st = M_WORD;
            else if (c == CH_BSL) lex_st = M_DQ_BS;
            else                  add_token(KIND_BYTE, c);
         end
         M_DQ_BS: begin
            if (c == CH_END) begin
               close_line(1'b0);  // backslash with nothing after it
            end else begin
               // only $ ` \ " lose their backslash inside double quotes
               if (!(c == CH_DOLL || c == CH_BTICK || c == CH_BSL || c == CH_DQ))
                  add_token(KIND_BYTE, CH_BSL);
               add_token(KIND_BYTE, c);
               lex_st = M_DQ;
            end
         end
         M_BS: begin
            if (c == CH_END) begin
               close_line(1'b0);
            end else begin
               add_token(KIND_BYTE, c);
               lex_st = M_WORD;
            end
         end
         M_WORD: begin
            if (c == CH_END || is_gap(c)) begin
               if (word_tally < COUNT_LIMIT) word_tally++;
               add_token(KIND_END, 8'h00);
               lex_st = M_BETWEEN;
               if (c == CH_END) close_line(1'b1);
            end else begin
               opens = 1'b1;
            end
         end
         default: begin
            lex_st = M_BETWEEN;
            if (c == CH_END)    close_line(word_tally != 8'd0);  // empty line is an error
            else if (!is_gap(c)) opens = 1'b1;
         end
      endcase
      // Byte that starts or carries on the unquoted part of a word.
      if (opens) begin
         case (c)
            CH_SQ:   lex_st = M_SQ;
            CH_DQ:   lex_st = M_DQ;
            CH_BSL:  lex_st = M_BS;
            default: begin
               add_token(KIND_BYTE, c);
               lex_st = M_WORD;
            end
         endcase
      end
      if (pend_n > 0) pend[pend_n - 1].last = 1'b1;
   endtask

   // ---------------------------------------------------------------------------------
   // Random byte helpers
   // ---------------------------------------------------------------------------------
   // Any non-zero byte, leaning towards the ones that steer the lexer.
   function automatic logic [7:0] rand_nz();
      logic [7:0] c;
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 7))
            0:       c = CH_SPACE;
            1:       c = CH_TAB;
            2:       c = CH_NL;
            3:       c = CH_SQ;
            4:       c = CH_DQ;
            5:       c = CH_BSL;
            6:       c = CH_DOLL;
            default: c = CH_BTICK;
         endcase
      end else begin
         c = 8'($urandom_range(1, 255));
      end
      return c;
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (is_gap(c) || c == CH_SQ || c == CH_DQ || c == CH_BSL);
      return c;
   endfunction

   function automatic logic [7:0] gap_char();
      logic [7:0] c;
      case ($urandom_range(0, 2))
         0:       c = CH_SPACE;
         1:       c = CH_TAB;
         default: c = CH_NL;
      endcase
      return c;
   endfunction

   // Builds one command line, end byte included, in line_q.
   // crowd: a line of more words than the count can hold, to drive it into saturation.
   // Otherwise mostly well-formed lines of quoted and escaped words, some cut short in
   // a quote or after a backslash, and some plain noise.
   task automatic compose_line(input logic crowd);
      int         shape;
      logic [7:0] c;
      line_q.delete();
      shape = $urandom_range(0, 99);
      if (crowd) begin
         repeat (int'(COUNT_LIMIT) + 3) begin
            line_q.push_back(plain_char());
            line_q.push_back(gap_char());
         end
      end else if (shape < 12) begin
         repeat ($urandom_range(0, 10)) line_q.push_back(rand_nz());
      end else begin
         if ($urandom_range(0, 3) == 0) line_q.push_back(gap_char());
         repeat ($urandom_range(1, 5)) begin
            repeat ($urandom_range(1, 3)) begin
               case ($urandom_range(0, 3))
                  0: repeat ($urandom_range(1, 4)) line_q.push_back(plain_char());
                  1: begin
                     line_q.push_back(CH_SQ);
                     repeat ($urandom_range(0, 3)) begin
                        do c = rand_nz(); while (c == CH_SQ);
                        line_q.push_back(c);
                     end
                     line_q.push_back(CH_SQ);
                  end
                  2: begin
                     line_q.push_back(CH_DQ);
                     repeat ($urandom_range(0, 3)) begin
                        if ($urandom_range(0, 2) == 0) begin
                           line_q.push_back(CH_BSL);
                           if ($urandom_range(0, 1) == 0) begin
                              case ($urandom_range(0, 3))
                                 0:       c = CH_DOLL;
                                 1:       c = CH_BTICK;
                                 2:       c = CH_BSL;
                                 default: c = CH_DQ;
                              endcase
                           end else begin
                              c = rand_nz();
                           end
                        end else begin
                           do c = rand_nz(); while (c == CH_DQ || c == CH_BSL);
                        end
                        line_q.push_back(c);
                     end
                     line_q.push_back(CH_DQ);
                  end
                  default: begin
                     line_q.push_back(CH_BSL);
                     line_q.push_back(rand_nz());
                  end
               endcase
            end
            if ($urandom_range(0, 4) != 0)
               repeat ($urandom_range(1, 2)) line_q.push_back(gap_char());
         end
         // broken tail before the end byte: an open quote or a dangling backslash
         if (shape < 27) begin
            case ($urandom_range(0, 3))
               0: begin
                  line_q.push_back(CH_SQ);
                  if ($urandom_range(0, 1) == 0) line_q.push_back(plain_char());
               end
               1: line_q.push_back(CH_DQ);
               2: line_q.push_back(CH_BSL);
               default: begin
                  line_q.push_back(CH_DQ);
                  line_q.push_back(CH_BSL);
               end
            endcase
         end
      end
      line_q.push_back(CH_END);
   endtask

   // ---------------------------------------------------------------------------------
   // Sender: called at a falling edge, returns at the falling edge after acceptance.
   // ---------------------------------------------------------------------------------
   task automatic send_row(input stim_row_t row);
      int k;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= row.ch;
      do @(posedge clock); while (!req_ready);
      // transaction taken at this edge: record what it owes
      item_cnt++;
      tokenise(row.ch);
      if (row.typed) begin
         if (row.n_typed > 2'd0) token_q.push_back(row.t0);
         if (row.n_typed > 2'd1) token_q.push_back(row.t1);
      end else begin
         for (k = 0; k < pend_n; k++) token_q.push_back(pend[k]);
      end
      @(negedge clock);
   endtask

   // Sender holds off until every owed token has come out; always passes a falling edge
   // so that req_valid is never driven twice in one step.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (token_q.size() != 0);
   endtask

   // ---------------------------------------------------------------------------------
   // Receiver: ready is redrawn at every falling edge.
   // ---------------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // ---------------------------------------------------------------------------------
   // Checker: each rsp transaction against the oldest owed token.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      token_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (token_q.size() == 0) begin
            if (fail_cnt < 10)
               $display("unexpected result: kind %0d byte %02h count %0d last %0b",
                        rsp_kind, rsp_byte_out, rsp_word_count, rsp_last);
            fail_cnt++;
         end else begin
            want = token_q.pop_front();
            if (rsp_kind !== want.kind || rsp_byte_out !== want.data ||
                rsp_word_count !== want.count || rsp_last !== want.last) begin
               if (fail_cnt < 10)
                  $display("mismatch (exp/act): kind %0d/%0d byte %02h/%02h count %0d/%0d last %0b/%0b",
                           want.kind, rsp_kind, want.data, rsp_byte_out,
                           want.count, rsp_word_count, want.last, rsp_last);
               fail_cnt++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Watchdog: too long without a single transaction on either side means a hang.
   // ---------------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------
   initial begin : stimulus
      int        ph;
      int        phase_end;
      stim_row_t row;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_char_in = 8'h00;

      // Directed line-up. Typed rows: empty line, byte extremes, word ends, done and errors.
      dir_tab[0]  = '{CH_END,   1'b1, 2'd1, tok(KIND_ERR,  8'h00, 8'd0, 1'b1), NO_TOKEN};
      dir_tab[1]  = '{8'hFF,    1'b1, 2'd1, tok(KIND_BYTE, 8'hFF, 8'd0, 1'b1), NO_TOKEN};
      dir_tab[2]  = '{8'h01,    1'b1, 2'd1, tok(KIND_BYTE, 8'h01, 8'd0, 1'b1), NO_TOKEN};
      dir_tab[3]  = '{CH_SPACE, 1'b1, 2'd1, tok(KIND_END,  8'h00, 8'd1, 1'b1), NO_TOKEN};
      // single quotes around a space, then double quotes with a kept and a dropped escape
      dir_tab[4]  = '{CH_SQ,    1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
      dir_tab[5]  = '{CH_SPACE, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
      dir_tab[6]  = '{CH_SQ,    1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
      dir_tab[7]  = '{CH_DQ,    1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
      dir_tab[8]  = '{CH_BSL,   1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
      dir_tab[9]  = '{CH_DOLL,  1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
      dir_tab[10] = '{CH_BSL,   1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
      dir_tab[11] = '{8'h61,    1'b0, 2'd0, NO_TOKEN, NO_TOKEN};  // backslash kept: two bytes
      dir_tab[12] = '{CH_DQ,    1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
      // escaped newline outside quotes, then the end byte closes the word
      dir_tab[13] = '{CH_BSL,   1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
      dir_tab[14] = '{CH_NL,    1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
      dir_tab[15] = '{CH_END,   1'b1, 2'd2, tok(KIND_END,  8'h00, 8'd2, 1'b0),
                                            tok(KIND_DONE, 8'h00, 8'd2, 1'b1)};
      // empty quoted word still counts
      dir_tab[16] = '{CH_SQ,    1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
      dir_tab[17] = '{CH_SQ,    1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
      dir_tab[18] = '{CH_TAB,   1'b1, 2'd1, tok(KIND_END,  8'h00, 8'd1, 1'b1), NO_TOKEN};
      // double quote left open
      dir_tab[19] = '{CH_DQ,    1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
      dir_tab[20] = '{CH_END,   1'b1, 2'd1, tok(KIND_ERR,  8'h00, 8'd1, 1'b1), NO_TOKEN};
      // trailing backslash, outside and then inside double quotes
      dir_tab[21] = '{CH_BSL,   1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
      dir_tab[22] = '{CH_END,   1'b1, 2'd1, tok(KIND_ERR,  8'h00, 8'd0, 1'b1), NO_TOKEN};
      dir_tab[23] = '{CH_DQ,    1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
      dir_tab[24] = '{CH_BSL,   1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
      dir_tab[25] = '{CH_END,   1'b1, 2'd1, tok(KIND_ERR,  8'h00, 8'd0, 1'b1), NO_TOKEN};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_tab[i]) send_row(dir_tab[i]);
      drain();

      // Random lines in four traffic phases; the sender waits for the queue to empty
      // between phases.
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 56; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 56; end
            default: begin idle_pct = 26; stall_pct = 26; end
         endcase
         phase_end = item_cnt + PHASE_ITEMS;
         if (ph == 0) begin
            compose_line(1'b1);  // word count runs into its ceiling
            foreach (line_q[i]) begin
               row    = '0;
               row.ch = line_q[i];
               send_row(row);
            end
         end
         while (item_cnt < phase_end) begin
            compose_line(1'b0);
            foreach (line_q[i]) begin
               row    = '0;
               row.ch = line_q[i];
               send_row(row);
            end
         end
         drain();
      end

      // Everything owed has arrived; let the clock run on so that any straggler still shows up.
      repeat (SETTLE_TICKS) @(negedge clock);
      if (fail_cnt == 0 && token_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
